[rtl/rsp_pkg.sv]
// shared types and register constants for the rule slot prefilter
`default_nettype none

package rsp_pkg;

    // field widths
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned LIMIT_W = 15;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_THREE_ALT = 1'b0,
        REG_SUPERFORM = 1'b1
    } reg_idx_t;

    // reset values of the registers
    localparam logic               THREE_ALT_RST = 1'b1;
    localparam logic [LIMIT_W-1:0] SUPERFORM_RST = 15'd19;

    // per-rule checking state
    typedef struct packed {
        logic class_done;
        logic form_done;
        logic rejected;
    } flags_t;

endpackage

`default_nettype wire

[rtl/rsp_elem_check.sv]
// compare logic for one rule element against the candidates of one word
`default_nettype none

module rsp_elem_check (
    input  wire logic                                  three_alt,
    input  wire logic [rsp_pkg::LIMIT_W-1:0]           superform_limit,
    input  wire rsp_pkg::flags_t                       flags,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    rule_class,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    rule_form,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    word_class_a,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    word_class_b,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    word_class_c,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    word_form_a,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    word_form_b,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    word_form_c,
    output rsp_pkg::flags_t                            flags_next
);

    logic class_zero;
    logic class_pos;
    logic class_hit;
    logic form_zero;
    logic form_pos;
    logic form_in_range;
    logic form_hit;
    logic class_miss;
    logic form_miss;

    // classify the rule values
    assign class_zero    = (rule_class == '0);
    assign class_pos     = !rule_class[rsp_pkg::FIELD_W-1] && !class_zero;
    assign form_zero     = (rule_form == '0);
    assign form_pos      = !rule_form[rsp_pkg::FIELD_W-1] && !form_zero;
    assign form_in_range = (rule_form[rsp_pkg::LIMIT_W-1:0] <= superform_limit);

    // candidate match, slots b and c only in three-slot mode
    assign class_hit = (rule_class == word_class_a) ||
                       (three_alt && ((rule_class == word_class_b) ||
                                      (rule_class == word_class_c)));
    assign form_hit  = (rule_form == word_form_a) ||
                       (three_alt && ((rule_form == word_form_b) ||
                                      (rule_form == word_form_c)));

    assign class_miss = !flags.class_done && class_pos && !class_hit;
    assign form_miss  = !flags.form_done && form_pos && form_in_range && !form_hit;

    // next flags
    always_comb begin
        flags_next.class_done = flags.class_done || class_zero;
        flags_next.form_done  = flags.form_done || form_zero;
        flags_next.rejected   = flags.rejected || class_miss || form_miss;
    end

endmodule

`default_nettype wire

[rtl/rule_slot_prefilter.sv]
// rule slot prefilter top level: input register, element check, verdict register
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  s_       | s_valid / s_ready  | rule_class, rule_form, word_class_a..c,
//           |                    | word_form_a..c, last_element
//  m_       | m_valid / m_ready  | verdict (0 possible match, 1 rejected)
//  apb      | psel / penable     | three_alternatives @0x0, superform_limit @0x4
//
// one item per cycle while no last element waits on the result register; each item
// passes the input register, and the verdict of a last element is registered in the
// result register as that element leaves the input register.
// reset clears the handshake state and the per-rule flags and loads register
// defaults. a waiting verdict stalls only a following last element; other
// items keep flowing and update the flags.
`default_nettype none

module rule_slot_prefilter #(
    parameter logic                            THREE_ALT_INIT = rsp_pkg::THREE_ALT_RST,
    parameter logic [rsp_pkg::LIMIT_W-1:0]     SUPERFORM_INIT = rsp_pkg::SUPERFORM_RST
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input items
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_rule_class,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_rule_form,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_word_class_a,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_word_class_b,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_word_class_c,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_word_form_a,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_word_form_b,
    input  wire logic signed [rsp_pkg::FIELD_W-1:0]    s_word_form_c,
    input  wire logic                                  s_last_element,
    // result items
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_verdict,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [rsp_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [rsp_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [rsp_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                       pready
);

    // configuration registers
    logic                           three_alt_reg;
    logic [rsp_pkg::LIMIT_W-1:0]    superform_reg;
    rsp_pkg::reg_idx_t              reg_idx;
    logic                           cfg_write;

    // input register
    logic                                  in_valid_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    rule_class_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    rule_form_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    word_class_a_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    word_class_b_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    word_class_c_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    word_form_a_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    word_form_b_reg;
    logic signed [rsp_pkg::FIELD_W-1:0]    word_form_c_reg;
    logic                                  last_reg;

    // per-rule state and result register
    rsp_pkg::flags_t    flags_reg;
    rsp_pkg::flags_t    flags_next;
    logic               out_valid_reg;
    logic               verdict_reg;

    logic out_free;
    logic advance;
    logic in_take;

    // apb decode
    assign reg_idx   = rsp_pkg::reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            three_alt_reg <= THREE_ALT_INIT;
            superform_reg <= SUPERFORM_INIT;
        end else if (cfg_write) begin
            case (reg_idx)
                rsp_pkg::REG_THREE_ALT: three_alt_reg <= pwdata[0];
                rsp_pkg::REG_SUPERFORM: superform_reg <= pwdata[rsp_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            rsp_pkg::REG_THREE_ALT:
                prdata = {{(rsp_pkg::APB_DATA_W-1){1'b0}}, three_alt_reg};
            rsp_pkg::REG_SUPERFORM:
                prdata = {{(rsp_pkg::APB_DATA_W-rsp_pkg::LIMIT_W){1'b0}}, superform_reg};
            default:
                prdata = '0;
        endcase
    end

    // flow control: a non-last element never waits for the result slot
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign in_take  = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            rule_class_reg   <= s_rule_class;
            rule_form_reg    <= s_rule_form;
            word_class_a_reg <= s_word_class_a;
            word_class_b_reg <= s_word_class_b;
            word_class_c_reg <= s_word_class_c;
            word_form_a_reg  <= s_word_form_a;
            word_form_b_reg  <= s_word_form_b;
            word_form_c_reg  <= s_word_form_c;
            last_reg         <= s_last_element;
        end
    end

    // element check
    rsp_elem_check u_check (
        .three_alt       (three_alt_reg),
        .superform_limit (superform_reg),
        .flags           (flags_reg),
        .rule_class      (rule_class_reg),
        .rule_form       (rule_form_reg),
        .word_class_a    (word_class_a_reg),
        .word_class_b    (word_class_b_reg),
        .word_class_c    (word_class_c_reg),
        .word_form_a     (word_form_a_reg),
        .word_form_b     (word_form_b_reg),
        .word_form_c     (word_form_c_reg),
        .flags_next      (flags_next)
    );

    // rule state, cleared once the verdict is taken into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (advance) begin
            if (last_reg) begin
                flags_reg <= '0;
            end else begin
                flags_reg <= flags_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            verdict_reg <= flags_next.rejected;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_verdict = verdict_reg;

`ifndef SYNTHESIS
    // a new verdict only follows a last element leaving the input register
    a_verdict_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && last_reg))
        else $error("verdict without a last element");

    // the rule state starts clean after every verdict
    a_flags_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> (flags_reg == '0))
        else $error("rule state not cleared after verdict");

    // a rejection holds for the rest of the rule
    a_reject_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !last_reg && flags_reg.rejected) |=> flags_reg.rejected)
        else $error("rejection lost within a rule");

    // a last element never overwrites a waiting verdict
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |-> (!out_valid_reg || m_ready))
        else $error("verdict overwritten");
`endif

endmodule

`default_nettype wire

[tb/rule_slot_prefilter_tb.sv]
// self-checking testbench for the rule slot prefilter: directed table, random rules, apb sweeps
`timescale 1ns / 100ps

module rule_slot_prefilter_tb;

    localparam int CLK_HALF      = 6;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ITEM  = 700;
    localparam int PHASE_ITEMS   = 275;
    localparam int PHASES        = 7;

    // per-phase settings; a negative limit means draw one at random
    localparam bit PHASE_ALT   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam int PHASE_LIMIT [PHASES] = '{19, 0, 32767, 32767, -1, -1, 19};

    typedef logic signed [rsp_pkg::FIELD_W-1:0] word_t;

    typedef struct packed {
        word_t rule_class;
        word_t rule_form;
        word_t class_a, class_b, class_c;
        word_t form_a, form_b, form_c;
        logic  last;
    } element_t;

    typedef struct packed {
        element_t e;
        logic     typed;
        logic     verdict;
    } stim_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_valid  = 1'b0;
    logic                           s_ready;
    element_t                       s_elem   = '0;
    logic                           m_valid;
    logic                           m_ready  = 1'b0;
    logic                           m_verdict;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rsp_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [rsp_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [rsp_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // mirror of the block's registers and per-rule flags
    logic                        cfg_three_alt = rsp_pkg::THREE_ALT_RST;
    logic [rsp_pkg::LIMIT_W-1:0] cfg_limit     = rsp_pkg::SUPERFORM_RST;
    logic                        class_ended   = 1'b0;
    logic                        form_ended    = 1'b0;
    logic                        rule_rejected = 1'b0;

    logic      verdicts_due[$];
    stim_row_t directed_rows[$];

    int items_sent    = 0;
    int verdicts_seen = 0;
    int rejects_seen  = 0;
    int errors        = 0;
    bit no_idle       = 1'b0;

    rule_slot_prefilter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rule_class   (s_elem.rule_class),
        .s_rule_form    (s_elem.rule_form),
        .s_word_class_a (s_elem.class_a),
        .s_word_class_b (s_elem.class_b),
        .s_word_class_c (s_elem.class_c),
        .s_word_form_a  (s_elem.form_a),
        .s_word_form_b  (s_elem.form_b),
        .s_word_form_c  (s_elem.form_c),
        .s_last_element (s_elem.last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (m_verdict),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // candidate match against the enabled slots
    function automatic logic slot_hit(input word_t want, input word_t a, input word_t b,
                                      input word_t c);
        if (want == a)
            return 1'b1;
        if (cfg_three_alt)
            return (want == b) || (want == c);
        return 1'b0;
    endfunction

    // advance the rule flags by one element; returns 1 when a verdict is due
    function automatic logic judge_element(input element_t e, output logic verdict);
        if (!class_ended) begin
            if (e.rule_class == 0)
                class_ended = 1'b1;
            else if (e.rule_class > 0 && !slot_hit(e.rule_class, e.class_a, e.class_b, e.class_c))
                rule_rejected = 1'b1;
        end
        if (!form_ended) begin
            if (e.rule_form == 0)
                form_ended = 1'b1;
            else if (e.rule_form > 0 && e.rule_form[rsp_pkg::LIMIT_W-1:0] <= cfg_limit &&
                     !slot_hit(e.rule_form, e.form_a, e.form_b, e.form_c))
                rule_rejected = 1'b1;
        end
        verdict = rule_rejected;
        if (!e.last)
            return 1'b0;
        class_ended   = 1'b0;
        form_ended    = 1'b0;
        rule_rejected = 1'b0;
        return 1'b1;
    endfunction

    function automatic stim_row_t row(input int rc, input int rf, input int ca, input int cb,
                                      input int cc, input int fa, input int fb, input int fc,
                                      input logic last, input logic typed, input logic verdict);
        stim_row_t r;
        r.e.rule_class = word_t'(rc);
        r.e.rule_form  = word_t'(rf);
        r.e.class_a    = word_t'(ca);
        r.e.class_b    = word_t'(cb);
        r.e.class_c    = word_t'(cc);
        r.e.form_a     = word_t'(fa);
        r.e.form_b     = word_t'(fb);
        r.e.form_c     = word_t'(fc);
        r.e.last       = last;
        r.typed        = typed;
        r.verdict      = verdict;
        return r;
    endfunction

    // rule value: zero, wildcard, small, near the superform limit or anywhere positive
    function automatic word_t rule_value(input bit for_form);
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel <= 2)
            return word_t'({1'b1, 15'($urandom)});
        if (sel <= 5)
            return word_t'($urandom_range(1, 8));
        if (sel <= 7 && for_form) begin
            v = int'(cfg_limit) + int'($urandom_range(0, 4)) - 2;
            if (v < 1)
                v = 1;
            if (v > 32767)
                v = 32767;
            return word_t'(v);
        end
        return word_t'({1'b0, 15'($urandom)});
    endfunction

    function automatic word_t candidate_word();
        if ($urandom_range(0, 1) != 0)
            return word_t'($urandom_range(0, 8));
        return word_t'($urandom);
    endfunction

    // fill the three slots, usually planting the wanted value in one of them
    function automatic void fill_slots(input word_t want, output word_t a, output word_t b,
                                       output word_t c);
        a = candidate_word();
        b = candidate_word();
        c = candidate_word();
        case ($urandom_range(0, 4))
            0, 1: a = want;
            2:    b = want;
            3:    c = want;
            default: ;
        endcase
    endfunction

    function automatic element_t make_element(input logic last);
        element_t e;
        if ($urandom_range(0, 9) == 0) begin
            // noise: every word field drawn freely
            e = {$urandom, $urandom, $urandom, $urandom, 1'b0};
        end else begin
            e.rule_class = rule_value(1'b0);
            fill_slots(e.rule_class, e.class_a, e.class_b, e.class_c);
            e.rule_form = rule_value(1'b1);
            fill_slots(e.rule_form, e.form_a, e.form_b, e.form_c);
        end
        e.last = last;
        return e;
    endfunction

    // offer one item, wait for acceptance, then record the verdict it causes
    task automatic send_element(input element_t e, input logic typed, input logic typed_verdict);
        logic verdict;
        logic due;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_elem  <= e;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        due = judge_element(e, verdict);
        if (due)
            verdicts_due.push_back(typed ? typed_verdict : verdict);
    endtask

    task automatic send_rule();
        int len;
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
            send_element(make_element(i == len - 1), 1'b0, 1'b0);
    endtask

    // one apb transfer: setup then access, with psel and penable dropped before it returns
    task automatic apb_access(input logic write, input rsp_pkg::reg_idx_t idx,
                              input logic [rsp_pkg::APB_DATA_W-1:0] wdata,
                              output logic [rsp_pkg::APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_register(input rsp_pkg::reg_idx_t idx,
                                input logic [rsp_pkg::APB_DATA_W-1:0] value);
        logic [rsp_pkg::APB_DATA_W-1:0] rd;
        apb_access(1'b1, idx, value, rd);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== value) begin
            $display("%0t: register %s read back, expected %0d, got %0d",
                     $time, idx.name(), value, rd);
            errors++;
        end
    endtask

    // stop offering, wait for every outstanding verdict, then let the pipeline settle
    task automatic drain_results();
        int n;
        s_valid <= 1'b0;
        n = 0;
        while (verdicts_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        if (verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts never arrived, next expected %0d, got none",
                     $time, verdicts_due.size(), verdicts_due[0]);
            errors++;
            verdicts_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold-off, none in the last phase
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // verdict checker
    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, got %0d", $time, m_verdict);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_verdict !== want) begin
                    $display("%0t: verdict mismatch, expected %0d, got %0d",
                             $time, want, m_verdict);
                    errors++;
                end
                verdicts_seen++;
                if (m_verdict)
                    rejects_seen++;
            end
        end
    end

    // stimulus
    initial begin
        int lim;
        int phase_start;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table under reset settings: three slots, limit 19
        //                           rc      rf   ca      cb     cc      fa  fb  fc lst typ v
        directed_rows.push_back(row(5,      3,      5,      0,     0,      3,  0,  0, 1, 1, 0));
        directed_rows.push_back(row(5,      3,      1,      2,     5,      1,  2,  3, 1, 1, 0));
        directed_rows.push_back(row(7,      4,      1,      7,     2,      9,  4,  9, 1, 1, 0));
        directed_rows.push_back(row(7,      -1,     1,      2,     3,      9,  9,  9, 1, 1, 1));
        directed_rows.push_back(row(1,      1,      1,      0,     0,      1,  0,  0, 1, 1, 0));
        directed_rows.push_back(row(-1,     -32768, 100,    200,   300,    5,  6,  7, 1, 1, 0));
        directed_rows.push_back(row(-32768, 20,     1,      2,     3,      1,  2,  3, 1, 1, 0));
        directed_rows.push_back(row(1,      19,     1,      0,     0,      18, 20, 1, 1, 1, 1));
        directed_rows.push_back(row(32767,  19,     -32768, 32767, 0,      0,  0,  19, 1, 1, 0));
        // a miss cannot be undone by a later match
        directed_rows.push_back(row(32767,  -1,     32766,  -1,    -32768, 0,  0,  0, 0, 0, 0));
        directed_rows.push_back(row(2,      2,      2,      2,     2,      2,  2,  2, 1, 1, 1));
        // both checks ended by zeros, then flags cleared by the verdict
        directed_rows.push_back(row(0,      0,      9,      9,     9,      9,  9,  9, 0, 0, 0));
        directed_rows.push_back(row(9,      9,      1,      2,     3,      1,  2,  3, 1, 1, 0));
        directed_rows.push_back(row(9,      9,      1,      2,     3,      1,  2,  3, 1, 1, 1));
        // class checks ended alone
        directed_rows.push_back(row(0,      -5,     1,      1,     1,      1,  1,  1, 0, 0, 0));
        directed_rows.push_back(row(3,      5,      4,      4,     4,      6,  5,  6, 1, 1, 0));
        // form checks ended alone
        directed_rows.push_back(row(-7,     0,      1,      1,     1,      1,  1,  1, 0, 0, 0));
        directed_rows.push_back(row(4,      11,     6,      6,     6,      1,  1,  1, 1, 1, 1));
        // zero carried by the last element itself
        directed_rows.push_back(row(0,      6,      1,      2,     3,      1,  2,  3, 1, 1, 1));
        directed_rows.push_back(row(8,      0,      8,      0,     0,      1,  1,  1, 1, 1, 0));
        // multi-element rules left to the predictor
        directed_rows.push_back(row(1,      1,      1,      1,     1,      1,  1,  1, 0, 0, 0));
        directed_rows.push_back(row(32767,  19,     32767,  0,     0,      19, 0,  0, 1, 0, 0));
        directed_rows.push_back(row(6,      -3,     0,      0,     6,      0,  0,  0, 0, 0, 0));
        directed_rows.push_back(row(-2,     7,      0,      0,     0,      0,  0,  8, 1, 0, 0));
        foreach (directed_rows[i])
            send_element(directed_rows[i].e, directed_rows[i].typed, directed_rows[i].verdict);

        // random rules over a sweep of settings
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            no_idle = (p == PHASES - 1);
            lim = (PHASE_LIMIT[p] < 0) ? int'($urandom_range(0, 32767)) : PHASE_LIMIT[p];
            set_register(rsp_pkg::REG_THREE_ALT, rsp_pkg::APB_DATA_W'(PHASE_ALT[p]));
            set_register(rsp_pkg::REG_SUPERFORM, rsp_pkg::APB_DATA_W'(lim));
            cfg_three_alt = PHASE_ALT[p];
            cfg_limit     = rsp_pkg::LIMIT_W'(lim);
            phase_start   = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_rule();
        end
        drain_results();

        $display("sent %0d elements: a directed table and %0d random phases over both slot modes,",
                 items_sent, PHASES);
        $display("limits 0 to 32767 and a long result stall; %0d verdicts checked, %0d rejects",
                 verdicts_seen, rejects_seen);
        if (errors == 0)
            $display("rule_slot_prefilter_tb OK");
        else
            $display("rule_slot_prefilter_tb NOT OK");
        $finish;
    end

    // overall time limit
    initial begin
        #TIMEOUT_NS;
        $display("%0t: run timed out with %0d verdicts outstanding", $time, verdicts_due.size());
        $display("rule_slot_prefilter_tb NOT OK");
        $finish;
    end

endmodule
